// File: src/gif_pkg.sv
// gif_pkg: shared types and constants for the grid interior fill block.
// No dependencies; imported by grid_interior_fill.

package gif_pkg;

  localparam int ROW_W    = 64;  // row_bits / filled_bits port width
  localparam int ROWNUM_W = 6;   // row_number port width
  localparam int CFG_W    = 7;   // config register width
  localparam int REG_IDX_W = 1;  // config register index width

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BACK,
    ST_BDRAIN,
    ST_FWD,
    ST_FDRAIN
  } fill_state_t;

endpackage

// File: src/grid_interior_fill.sv
// grid_interior_fill: loads a binary grid one row per beat, then fills interior holes
// reachable in all four directions and emits every row. Depends on gif_pkg.
//
// Loading: one row per beat, one row per cycle while not busy. On the row marked last the
// block goes busy (h = clamped grid height): a backward walk over the row store from row
// h-1 down to row 0 plus a drain state, a forward walk from row 0 to row h-1 through the
// shared fill unit and a drain state. Results stream out in row order behind the forward
// walk, one per cycle, as single-cycle strobes; the receiver cannot stall. Reset (rst, synchronous)
// empties the store by zeroing the fill count and sets width and height to 64.

module grid_interior_fill
  import gif_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ROW_W-1:0]     row_bits,
  input  logic                 last_row,
  output logic                 result_valid,
  output logic [ROWNUM_W-1:0]  row_number,
  output logic [ROW_W-1:0]     filled_bits,
  output logic                 last_result,
  input  logic                 write_enable,
  input  logic [REG_IDX_W-1:0] reg_index,
  input  logic [CFG_W-1:0]     write_data
);

  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int RLW = $clog2(MAX_HEIGHT + 1);
  localparam logic [CFG_W-1:0] MAX_W_C = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] MAX_H_C = CFG_W'(MAX_HEIGHT);

  // Config registers
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  // Row stores
  logic [MAX_WIDTH-1:0] grid_mem  [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] below_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] grid_q;
  logic [MAX_WIDTH-1:0] below_q;

  fill_state_t      state;
  fill_state_t      state_next;
  logic [RLW-1:0]   rows_loaded;
  logic [YW-1:0]    rd_y;
  logic [YW-1:0]    s1_idx;
  logic             bk_valid;
  logic             fw_valid;
  logic             issue_back;
  logic             issue_fwd;
  logic             accept;
  logic [MAX_WIDTH-1:0] acc;
  logic [MAX_WIDTH-1:0] above;

  // Clamped sizes and masks
  logic [CFG_W-1:0]     w_eff;
  logic [CFG_W-1:0]     h_eff;
  logic [MAX_WIDTH-1:0] wm;
  logic [MAX_WIDTH-1:0] inner;

  // Shared fill unit
  logic                 row_ok;
  logic [MAX_WIDTH-1:0] row_cur;
  logic [MAX_WIDTH-1:0] acc_next;
  logic [MAX_WIDTH-1:0] above_next;
  logic [MAX_WIDTH-1:0] low_bit;
  logic [MAX_WIDTH-1:0] left_r;
  logic [MAX_WIDTH-1:0] right_r;
  logic [MAX_WIDTH-1:0] fill;
  logic [MAX_WIDTH-1:0] res;
  logic                 interior;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= MAX_W_C;
      grid_height <= MAX_H_C;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_GRID_WIDTH:  grid_width  <= write_data;
        REG_GRID_HEIGHT: grid_height <= write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width == '0)        w_eff = CFG_W'(1);
    else if (grid_width > MAX_W_C) w_eff = MAX_W_C;
    else                          w_eff = grid_width;
    if (grid_height == '0)         h_eff = CFG_W'(1);
    else if (grid_height > MAX_H_C) h_eff = MAX_H_C;
    else                           h_eff = grid_height;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      wm[i]    = (i < int'(w_eff));
      inner[i] = (i >= 1) && ((i + 1) < int'(w_eff));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    issue_back = 1'b0;
    issue_fwd  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && last_row) state_next = ST_BACK;
      end
      ST_BACK: begin
        issue_back = 1'b1;
        if (rd_y == '0) state_next = ST_BDRAIN;
      end
      // lets the write of row 0 into below_mem land before the forward reads
      ST_BDRAIN: begin
        state_next = ST_FWD;
      end
      ST_FWD: begin
        issue_fwd = 1'b1;
        if (CFG_W'(rd_y) + CFG_W'(1) == h_eff) state_next = ST_FDRAIN;
      end
      ST_FDRAIN: begin
        if (!fw_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded  <= '0;
      rd_y         <= '0;
      bk_valid     <= 1'b0;
      fw_valid     <= 1'b0;
      result_valid <= 1'b0;
      acc          <= '0;
      above        <= '0;
    end else begin
      bk_valid     <= issue_back;
      fw_valid     <= issue_fwd;
      result_valid <= fw_valid;
      if (accept) begin
        if (rows_loaded < RLW'(MAX_HEIGHT)) rows_loaded <= rows_loaded + RLW'(1);
        if (last_row) begin
          rd_y <= YW'(h_eff - CFG_W'(1));
          acc  <= '0;
        end
      end
      if (issue_back && rd_y != '0) rd_y <= rd_y - YW'(1);
      if (issue_fwd) rd_y <= rd_y + YW'(1);
      if (state == ST_BDRAIN) above <= '0;
      if (bk_valid) acc <= acc_next;
      if (fw_valid) above <= above_next;
      if (state == ST_FDRAIN && !fw_valid) rows_loaded <= '0;
    end
  end

  // Store access: one write and one registered read per memory
  always_ff @(posedge clk) begin
    if (accept && rows_loaded < RLW'(MAX_HEIGHT))
      grid_mem[rows_loaded[YW-1:0]] <= row_bits[MAX_WIDTH-1:0];
    grid_q <= grid_mem[rd_y];
  end

  always_ff @(posedge clk) begin
    if (bk_valid) below_mem[s1_idx] <= acc_next;
    below_q <= below_mem[rd_y];
  end

  always_ff @(posedge clk) begin
    s1_idx <= rd_y;
    if (fw_valid) begin
      row_number  <= ROWNUM_W'(s1_idx);
      filled_bits <= ROW_W'(res);
      last_result <= (CFG_W'(s1_idx) + CFG_W'(1) == h_eff);
    end
  end

  // Fill unit: rows past the fill count read as zero
  always_comb begin
    row_ok     = RLW'(s1_idx) < rows_loaded;
    row_cur    = row_ok ? (grid_q & wm) : '0;
    acc_next   = acc | row_cur;
    above_next = above | row_cur;
    low_bit    = row_cur & (~row_cur + MAX_WIDTH'(1));
    left_r     = ~(low_bit - MAX_WIDTH'(1));
    right_r    = row_cur;
    for (int s = 1; s < MAX_WIDTH; s = s * 2) begin
      right_r = right_r | (right_r >> s);
    end
    fill     = left_r & right_r & above_next & below_q & inner;
    interior = (s1_idx != '0) && (CFG_W'(s1_idx) + CFG_W'(1) < h_eff);
    res      = interior ? (row_cur | fill) : row_cur;
  end

  // Checks
  a_result_in_walk: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == ST_FWD || state == ST_FDRAIN))
    else $error("result beat outside forward walk");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |=> (state == ST_IDLE && rows_loaded == '0))
    else $error("block not idle after final beat");

  a_walks_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(bk_valid && fw_valid))
    else $error("backward and forward walks overlap");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rows_loaded <= RLW'(MAX_HEIGHT))
    else $error("fill count past store depth");

endmodule

// File: sim/grid_interior_fill_tb.sv
// grid_interior_fill_tb: self-checking testbench for grid_interior_fill.
// Loads grids one row per beat, predicts every filled row and checks each strobe.
// Depends on gif_pkg and grid_interior_fill.
`timescale 1ns / 100ps

module grid_interior_fill_tb
  import gif_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_ROWS    = 64;

  typedef struct packed {
    logic [ROWNUM_W-1:0] row_number;
    logic [ROW_W-1:0]    bits;
    logic                is_last;
  } filled_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [ROW_W-1:0]     row_bits;
  logic                 last_row;
  logic                 result_valid;
  logic [ROWNUM_W-1:0]  row_number;
  logic [ROW_W-1:0]     filled_bits;
  logic                 last_result;
  logic                 write_enable;
  logic [REG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     write_data;

  // mirror of the block: register copies and the row store
  logic [CFG_W-1:0] size_w;
  logic [CFG_W-1:0] size_h;
  logic [ROW_W-1:0] loaded_rows [MAX_ROWS];
  int               rows_held;

  filled_row_t fill_q [$];
  filled_row_t want;
  int          errors;
  int          cycles;

  grid_interior_fill dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .row_bits     (row_bits),
    .last_row     (last_row),
    .result_valid (result_valid),
    .row_number   (row_number),
    .filled_bits  (filled_bits),
    .last_result  (last_result),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int eff_size(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic void log_fault(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Store one row; on the last one compute the filled grid and queue every row.
  function automatic void take_row(input logic [ROW_W-1:0] bits, input logic is_last);
    int          w;
    int          h;
    int          y;
    int          x;
    logic [63:0] wm;
    logic [63:0] inner;
    logic [63:0] r;
    logic [63:0] acc;
    logic [63:0] up;
    logic [63:0] lr;
    logic [63:0] rr;
    logic [63:0] down [MAX_ROWS];
    logic        seen;
    filled_row_t e;
    if (rows_held < MAX_ROWS) begin
      loaded_rows[rows_held] = bits;
      rows_held++;
    end
    if (!is_last) return;
    w = eff_size(size_w);
    h = eff_size(size_h);
    wm = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    inner = wm;
    inner[0] = 1'b0;
    inner[w-1] = 1'b0;
    acc = '0;
    for (y = h - 1; y >= 0; y--) begin
      acc |= loaded_rows[y] & wm;
      down[y] = acc;
    end
    up = '0;
    for (y = 0; y < h; y++) begin
      r = loaded_rows[y] & wm;
      up |= r;
      e.bits = r;
      if (y > 0 && y + 1 < h) begin
        // lr: a set cell at or left of x; rr: at or right of x
        seen = 1'b0;
        for (x = 0; x < 64; x++) begin
          seen |= r[x];
          lr[x] = seen;
        end
        seen = 1'b0;
        for (x = 63; x >= 0; x--) begin
          seen |= r[x];
          rr[x] = seen;
        end
        e.bits = r | (lr & rr & up & down[y] & inner);
      end
      e.row_number = y[ROWNUM_W-1:0];
      e.is_last = (y + 1 == h);
      fill_q.push_back(e);
    end
    for (y = 0; y < MAX_ROWS; y++) loaded_rows[y] = '0;
    rows_held = 0;
  endfunction

  // Acceptance, config mirror and result checks, all at the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (rst) begin
      size_w = 7'd64;
      size_h = 7'd64;
      for (int i = 0; i < MAX_ROWS; i++) loaded_rows[i] = '0;
      rows_held = 0;
    end else begin
      if (write_enable) begin
        case (reg_index)
          REG_GRID_WIDTH:  size_w = write_data;
          REG_GRID_HEIGHT: size_h = write_data;
          default: ;
        endcase
      end
      if (result_valid) begin
        if (fill_q.size() == 0) begin
          log_fault($sformatf("row %0d emitted with nothing expected", row_number));
        end else begin
          want = fill_q.pop_front();
          if (row_number !== want.row_number)
            log_fault($sformatf("row_number: expected %0d got %0d",
                                want.row_number, row_number));
          if (filled_bits !== want.bits)
            log_fault($sformatf("row %0d filled_bits: expected %h got %h",
                                want.row_number, want.bits, filled_bits));
          if (last_result !== want.is_last)
            log_fault($sformatf("row %0d last_result: expected %b got %b",
                                want.row_number, want.is_last, last_result));
        end
      end
      if (start && !busy) take_row(row_bits, last_row);
    end
  end

  // One beat: optional gap, then hold start until the block takes it.
  task automatic send_row(input logic [ROW_W-1:0] bits, input logic is_last, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    row_bits <= bits;
    last_row <= is_last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (fill_q.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_drained();
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index    <= REG_GRID_WIDTH;
    write_data   <= w;
    @(negedge clk);
    reg_index  <= REG_GRID_HEIGHT;
    write_data <= h;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] pick_row(input int style, input int w);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] rim;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    rim = 64'd1 | (64'd1 << (w - 1));
    case (style)
      0:       return a;
      1:       return a & b & c;
      2:       return a | b;
      3:       return rim | (a & b & c);
      4:       return '1;
      default: return '0;
    endcase
  endfunction

  // reset sizes: a framed hole fills across the whole 64-column row
  task automatic test_default_size();
    send_row('1, 1'b0, 0);
    send_row(64'h8000_0000_0000_0001, 1'b0, 0);
    send_row(64'h8000_0001_0000_0001, 1'b0, 3);
    send_row('1, 1'b1, 0);
  endtask

  // smallest interior, no interior, and zero sizes acting as one
  task automatic test_tiny_grids();
    set_size(7'd3, 7'd3);
    send_row('1, 1'b0, 0);
    send_row(64'hFFFF_0000_0000_0005, 1'b0, 0);
    send_row(64'h7, 1'b1, 0);
    send_row(64'h5, 1'b0, 2);
    send_row(64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 0);
    send_row(64'h5, 1'b1, 0);
    set_size(7'd2, 7'd2);
    send_row('1, 1'b1, 0);
    set_size(7'd1, 7'd1);
    send_row('1, 1'b1, 0);
    set_size(7'd0, 7'd0);
    send_row('1, 1'b1, 0);
  endtask

  // sizes above the maximum clamp to 64; then a 64-wide grid of height 3
  task automatic test_size_clamp();
    set_size(7'd127, 7'd127);
    send_row('1, 1'b0, 0);
    send_row(64'h8000_0000_0000_0001, 1'b0, 0);
    send_row('1, 1'b1, 0);
    set_size(7'd64, 7'd3);
    send_row(64'h0000_0000_0000_0100, 1'b0, 0);
    send_row(64'h8000_0000_0000_0001, 1'b0, 1);
    send_row(64'h0100_0000_0000_0000, 1'b1, 0);
  endtask

  // rows from the height onward are stored but play no part
  task automatic test_rows_past_height();
    set_size(7'd8, 7'd4);
    send_row(64'hFF, 1'b0, 0);
    send_row(64'h81, 1'b0, 0);
    send_row(64'h81, 1'b0, 0);
    send_row(64'h00, 1'b0, 0);
    send_row(64'hFF, 1'b0, 0);
    send_row(64'hFF, 1'b0, 0);
    send_row(64'hFF, 1'b1, 0);
  endtask

  // more than 64 rows: extra beats are not stored, though the last one still starts the fill
  task automatic test_row_overflow();
    int y;
    set_size(7'd64, 7'd64);
    for (y = 0; y < 70; y++)
      send_row(pick_row((y == 0 || y == 63) ? 4 : (y < 64 ? 3 : 0), 64), y == 69,
               $urandom_range(0, 2));
  endtask

  task automatic test_random_grids();
    int   rand_rows;
    int   rows;
    int   w_eff;
    int   h_eff;
    int   y;
    int   sel;
    int   style;
    bit   calm;
    bit   framed;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] extremes [5];
    extremes = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127};
    rand_rows = 0;
    while (rand_rows < 110) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          w = CFG_W'($urandom_range(3, 12));
          h = CFG_W'($urandom_range(3, 10));
        end else if (sel == 7) begin
          w = extremes[$urandom_range(0, 4)];
          h = extremes[$urandom_range(0, 4)];
        end else begin
          w = CFG_W'($urandom_range(0, 127));
          h = CFG_W'($urandom_range(0, 127));
        end
        set_size(w, h);
      end else if (sel == 6) begin
        wait_drained();
      end
      w_eff = eff_size(size_w);
      h_eff = eff_size(size_h);
      if (h_eff <= 16) begin
        sel = $urandom_range(0, 5);
        if (sel == 0) rows = $urandom_range(1, h_eff);
        else if (sel == 1) rows = h_eff + $urandom_range(1, 3);
        else rows = h_eff;
      end else begin
        rows = ($urandom_range(0, 3) == 0) ? h_eff : $urandom_range(1, 6);
      end
      framed = ($urandom_range(0, 3) != 0);
      calm   = ($urandom_range(0, 2) == 0);
      for (y = 0; y < rows; y++) begin
        if (framed)
          style = (y == 0 || y == h_eff - 1) ? ($urandom_range(0, 1) ? 4 : 2) : 3;
        else
          style = $urandom_range(0, 5);
        send_row(pick_row(style, w_eff), y == rows - 1, calm ? 0 : $urandom_range(0, 12));
        rand_rows++;
      end
    end
  endtask

  initial begin
    errors       = 0;
    cycles       = 0;
    rst          = 1'b1;
    start        = 1'b0;
    row_bits     = '0;
    last_row     = 1'b0;
    write_enable = 1'b0;
    reg_index    = REG_GRID_WIDTH;
    write_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_size();
    test_tiny_grids();
    test_size_clamp();
    test_rows_past_height();
    test_row_overflow();
    test_random_grids();

    wait_drained();
    repeat (80) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
